// ===== rtl/assert_macros.svh =====
// Assertion shorthands used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked on the same edge as the antecedent.
`define PRRQ_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked on the edge after the antecedent.
`define PRRQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/prrq_pkg.sv =====
package prrq_pkg;

  localparam int DEF_NUM_LEVELS = 8;
  localparam int DEF_NUM_PROCS  = 32;

  localparam int MODE_W     = 2;
  localparam int ID_W       = 5;
  localparam int PRI_W      = 3;
  localparam int STATUS_W   = 2;
  localparam int MASK_OUT_W = 8;
  localparam int KIND_W     = 3;

  localparam logic [MODE_W-1:0] MODE_ADD      = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REMOVE   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DISPATCH = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd2;

  // What the captured transaction turns out to need
  localparam logic [KIND_W-1:0] KIND_NOP      = 3'd0;
  localparam logic [KIND_W-1:0] KIND_IGNORE   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_EMPTY    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_ADD_NEW  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_ADD_RING = 3'd4;
  localparam logic [KIND_W-1:0] KIND_REMOVE   = 3'd5;
  localparam logic [KIND_W-1:0] KIND_DISPATCH = 3'd6;

  typedef struct packed {
    logic capture;
    logic issue_rd;
    logic decode;
    logic add_new;
    logic add_w1;
    logic add_w2;
    logic rem_w;
    logic disp_sel;
    logic load_out;
  } prrq_cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
  } prrq_sts_t;

endpackage

// ===== rtl/prrq_ctrl.sv =====
module prrq_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  prrq_pkg::prrq_sts_t sts,
  output prrq_pkg::prrq_cmd_t cmd
);
  import prrq_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_ADD_W1 = 3'd2;
  localparam logic [2:0] S_ADD_W2 = 3'd3;
  localparam logic [2:0] S_REM_W  = 3'd4;
  localparam logic [2:0] S_DISP   = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0] state, state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.issue_rd = 1'b1;
        cmd.decode   = 1'b1;
        cmd.add_new  = (sts.kind == KIND_ADD_NEW);
        unique case (sts.kind)
          KIND_ADD_RING: state_next = S_ADD_W1;
          KIND_REMOVE:   state_next = S_REM_W;
          KIND_DISPATCH: state_next = S_DISP;
          default:       state_next = S_DONE;
        endcase
      end
      S_ADD_W1: begin
        cmd.add_w1 = 1'b1;
        state_next = S_ADD_W2;
      end
      S_ADD_W2: begin
        cmd.add_w2 = 1'b1;
        state_next = S_DONE;
      end
      S_REM_W: begin
        cmd.rem_w  = 1'b1;
        state_next = S_DONE;
      end
      S_DISP: begin
        cmd.disp_sel = 1'b1;
        state_next   = S_DONE;
      end
      S_DONE: begin
        // wait for the output register to free up
        if (!out_valid || !out_stall) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/prrq_dpath.sv =====
module prrq_dpath #(
  parameter int NUM_LEVELS = prrq_pkg::DEF_NUM_LEVELS,
  parameter int NUM_PROCS  = prrq_pkg::DEF_NUM_PROCS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  prrq_pkg::prrq_cmd_t                cmd,
  output prrq_pkg::prrq_sts_t                sts,
  input  logic [prrq_pkg::MODE_W-1:0]        mode,
  input  logic [prrq_pkg::ID_W-1:0]          proc_id,
  input  logic [prrq_pkg::PRI_W-1:0]         proc_priority,
  input  logic [prrq_pkg::ID_W-1:0]          active_id,
  output logic [prrq_pkg::ID_W-1:0]          chosen_id,
  output logic [prrq_pkg::STATUS_W-1:0]      status,
  output logic [prrq_pkg::MASK_OUT_W-1:0]    ready_mask
);
  import prrq_pkg::*;

  localparam int PID_W = $clog2(NUM_PROCS);
  localparam int LVL_W = $clog2(NUM_LEVELS);
  localparam int IDX_W = (PID_W > ID_W) ? PID_W : ID_W;
  localparam int MW    = (NUM_LEVELS > MASK_OUT_W) ? NUM_LEVELS : MASK_OUT_W;
  localparam logic [LVL_W-1:0] TOP_LVL = LVL_W'(NUM_LEVELS - 1);

  // captured transaction
  logic [MODE_W-1:0] mode_r;
  logic [ID_W-1:0]   pid_r;
  logic [PRI_W-1:0]  pri_r;
  logic [ID_W-1:0]   act_r;

  // scheduler state
  logic [PID_W-1:0]      head [NUM_LEVELS];
  logic [NUM_LEVELS-1:0] mask;
  logic [NUM_PROCS-1:0]  queued;

  // link memories
  logic [PID_W-1:0] nxt_mem [NUM_PROCS];
  logic [PID_W-1:0] prv_mem [NUM_PROCS];
  logic [LVL_W-1:0] lvl_mem [NUM_PROCS];
  logic [PID_W-1:0] nxt_rd, prv_rd;
  logic [LVL_W-1:0] lvl_rd;

  logic [IDX_W-1:0] pid_wide, act_wide;
  logic [PID_W-1:0] pid_idx, act_idx;
  logic             pid_ok, act_ok, pid_q, act_q;
  logic [LVL_W-1:0] lv_add, top_lvl, hd_idx;
  logic [PID_W-1:0] head_sel;
  logic [KIND_W-1:0] kind;
  logic [PID_W-1:0] rd_a, rd_b;
  logic             rem_single;

  logic             nxt_we, prv_we, lvl_we;
  logic [PID_W-1:0] nxt_wa, prv_wa, lvl_wa;
  logic [PID_W-1:0] nxt_wd, prv_wd;
  logic [LVL_W-1:0] lvl_wd;

  logic [STATUS_W-1:0] res_status;
  logic [PID_W-1:0]    res_chosen;
  logic [IDX_W-1:0]    chosen_wide;
  logic [MW-1:0]       mask_wide;

  assign pid_wide = IDX_W'(pid_r);
  assign act_wide = IDX_W'(act_r);
  assign pid_idx  = pid_wide[PID_W-1:0];
  assign act_idx  = act_wide[PID_W-1:0];
  assign pid_ok   = (32'(pid_r) < 32'(NUM_PROCS));
  assign act_ok   = (32'(act_r) < 32'(NUM_PROCS));
  assign pid_q    = pid_ok && queued[pid_idx];
  assign act_q    = act_ok && queued[act_idx];

  assign lv_add = (32'(pri_r) >= 32'(NUM_LEVELS)) ? TOP_LVL : LVL_W'(pri_r);

  always_comb begin
    top_lvl = '0;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      if (mask[i]) begin
        top_lvl = LVL_W'(i);
      end
    end
  end

  // one read port on the head table, shared by add and dispatch
  assign hd_idx   = (mode_r == MODE_DISPATCH) ? top_lvl : lv_add;
  assign head_sel = head[hd_idx];

  always_comb begin
    unique case (mode_r)
      MODE_ADD: begin
        if (!pid_ok || pid_q) begin
          kind = KIND_IGNORE;
        end else if (!mask[lv_add]) begin
          kind = KIND_ADD_NEW;
        end else begin
          kind = KIND_ADD_RING;
        end
      end
      MODE_REMOVE:   kind = pid_q ? KIND_REMOVE : KIND_IGNORE;
      MODE_DISPATCH: kind = (mask == '0) ? KIND_EMPTY : KIND_DISPATCH;
      default:       kind = KIND_NOP;
    endcase
  end

  assign sts.kind = kind;

  // add reads the tail (prev of head); remove reads its own id, dispatch the active id
  assign rd_a = (mode_r == MODE_DISPATCH) ? act_idx : pid_idx;
  assign rd_b = (mode_r == MODE_ADD) ? head_sel : pid_idx;

  assign rem_single = (nxt_rd == pid_idx);

  always_comb begin
    nxt_we = 1'b0;
    prv_we = 1'b0;
    lvl_we = 1'b0;
    nxt_wa = pid_idx;
    prv_wa = pid_idx;
    lvl_wa = pid_idx;
    nxt_wd = pid_idx;
    prv_wd = pid_idx;
    lvl_wd = lv_add;
    if (cmd.add_new) begin
      nxt_we = 1'b1;
      prv_we = 1'b1;
      lvl_we = 1'b1;
    end else if (cmd.add_w1) begin
      nxt_we = 1'b1;
      prv_we = 1'b1;
      lvl_we = 1'b1;
      nxt_wd = head_sel;
      prv_wd = prv_rd;
    end else if (cmd.add_w2) begin
      // link old tail and head to the newcomer
      nxt_we = 1'b1;
      prv_we = 1'b1;
      nxt_wa = prv_rd;
      prv_wa = head_sel;
    end else if (cmd.rem_w && !rem_single) begin
      nxt_we = 1'b1;
      prv_we = 1'b1;
      prv_wa = nxt_rd;
      prv_wd = prv_rd;
      nxt_wa = prv_rd;
      nxt_wd = nxt_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (nxt_we) begin
      nxt_mem[nxt_wa] <= nxt_wd;
    end
    if (prv_we) begin
      prv_mem[prv_wa] <= prv_wd;
    end
    if (lvl_we) begin
      lvl_mem[lvl_wa] <= lvl_wd;
    end
    if (cmd.issue_rd) begin
      nxt_rd <= nxt_mem[rd_a];
      lvl_rd <= lvl_mem[rd_a];
      prv_rd <= prv_mem[rd_b];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
        head[i] <= '0;
      end
      mask   <= '0;
      queued <= '0;
    end else begin
      if (cmd.add_new) begin
        head[lv_add]    <= pid_idx;
        mask[lv_add]    <= 1'b1;
        queued[pid_idx] <= 1'b1;
      end
      if (cmd.add_w2) begin
        queued[pid_idx] <= 1'b1;
      end
      if (cmd.rem_w) begin
        queued[pid_idx] <= 1'b0;
        if (rem_single) begin
          head[lvl_rd] <= '0;
          mask[lvl_rd] <= 1'b0;
        end else begin
          head[lvl_rd] <= nxt_rd;
        end
      end
    end
  end

  assign chosen_wide = IDX_W'(res_chosen);
  assign mask_wide   = MW'(mask);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r <= mode;
      pid_r  <= proc_id;
      pri_r  <= proc_priority;
      act_r  <= active_id;
    end
    if (cmd.decode) begin
      res_chosen <= '0;
      if (kind == KIND_IGNORE) begin
        res_status <= ST_IGNORED;
      end else if (kind == KIND_EMPTY) begin
        res_status <= ST_EMPTY;
      end else begin
        res_status <= ST_OK;
      end
    end
    if (cmd.disp_sel) begin
      res_chosen <= (act_q && (lvl_rd == top_lvl)) ? nxt_rd : head_sel;
    end
    if (cmd.load_out) begin
      chosen_id  <= chosen_wide[ID_W-1:0];
      status     <= res_status;
      ready_mask <= mask_wide[MASK_OUT_W-1:0];
    end
  end

endmodule

// ===== rtl/priority_round_robin_ready_queue_unit.sv =====
// Multilevel ready queue: one circular doubly linked ring of process ids per
// priority level, a head per level and a bitmap of non-empty levels. Items are
// add, remove or dispatch; each gives one result (chosen id, status, level
// bitmap after the step). One item is worked at a time, stepped by a small
// sequencer over single-write-port link memories with registered reads: an item
// is captured and decoded, then a remove gets one link-write step, a dispatch
// one select step and an add to an occupied level two link-write steps after
// one read of the tail; ignored, empty, unused-mode items and an add to an
// empty level go straight to the result. The input is taken again as soon as
// the result moves into the output register, even if it is not yet collected.
module priority_round_robin_ready_queue_unit #(
  parameter int NUM_LEVELS = prrq_pkg::DEF_NUM_LEVELS,
  parameter int NUM_PROCS  = prrq_pkg::DEF_NUM_PROCS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [prrq_pkg::MODE_W-1:0]     mode,
  input  logic [prrq_pkg::ID_W-1:0]       proc_id,
  input  logic [prrq_pkg::PRI_W-1:0]      proc_priority,
  input  logic [prrq_pkg::ID_W-1:0]       active_id,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [prrq_pkg::ID_W-1:0]       chosen_id,
  output logic [prrq_pkg::STATUS_W-1:0]   status,
  output logic [prrq_pkg::MASK_OUT_W-1:0] ready_mask
);
  import prrq_pkg::*;

  prrq_cmd_t cmd;
  prrq_sts_t sts;

  prrq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  prrq_dpath #(
    .NUM_LEVELS (NUM_LEVELS),
    .NUM_PROCS  (NUM_PROCS)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .mode          (mode),
    .proc_id       (proc_id),
    .proc_priority (proc_priority),
    .active_id     (active_id),
    .chosen_id     (chosen_id),
    .status        (status),
    .ready_mask    (ready_mask)
  );

endmodule

// ===== rtl/prrq_checker.sv =====
`include "assert_macros.svh"

module prrq_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [prrq_pkg::ID_W-1:0]       chosen_id,
  input logic [prrq_pkg::STATUS_W-1:0]   status,
  input logic [prrq_pkg::MASK_OUT_W-1:0] ready_mask
);
  import prrq_pkg::*;

  // a transaction keeps the input closed while it is worked
  `PRRQ_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall, "input not stalled after accept")

  `PRRQ_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(chosen_id) && $stable(status) && $stable(ready_mask), "stalled result changed")

  `PRRQ_ASSERT_SAME(a_status_code, clk, rst, out_valid, status == ST_OK || status == ST_EMPTY || status == ST_IGNORED, "reserved status code")

  `PRRQ_ASSERT_SAME(a_empty_result, clk, rst, out_valid && status == ST_EMPTY, ready_mask == '0 && chosen_id == '0, "empty dispatch with ready levels or an id")

  `PRRQ_ASSERT_SAME(a_chosen_only_ok, clk, rst, out_valid && chosen_id != '0, status == ST_OK, "id chosen on a failed transaction")

endmodule

bind priority_round_robin_ready_queue_unit prrq_checker u_prrq_checker (.*);
